// ===== rtl/ddo_pkg.sv =====
package ddo_pkg;

  localparam int POSITION_BITS = 32;
  localparam int HEADING_BITS  = 16;

  localparam int SPEED_BITS   = 16;
  localparam int TIME_BITS    = 16;
  localparam int FACTOR_BITS  = 16;
  localparam int RATE_BITS    = 32;

  localparam int SUM_BITS     = SPEED_BITS + 1;
  localparam int STEP_BITS    = SUM_BITS + TIME_BITS + 1;

  localparam int MUL_A_BITS   = 34;
  localparam int MUL_B_BITS   = 32;
  localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

  localparam int CORDIC_BITS  = 33;
  localparam int TRIG_BITS    = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_BITS    = 4;
  localparam logic signed [CORDIC_BITS-1:0] CORDIC_START = 33'sd652032874;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd23179;
  localparam logic REG_FACTOR = 1'b0;

  localparam int XY_SHIFT   = 43;
  localparam int TH_SHIFT   = 28;
  localparam int RATE_SHIFT = 12;
  localparam int DELTA_BITS = MUL_P_BITS - XY_SHIFT;

  typedef struct packed {
    logic        [TIME_BITS-1:0]  elapsed_time;
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
  } ddo_in_t;

  typedef struct packed {
    logic signed [POSITION_BITS-1:0] position_x;
    logic signed [POSITION_BITS-1:0] position_y;
    logic        [HEADING_BITS-1:0]  heading_angle;
    logic signed [SPEED_BITS-1:0]    linear_velocity;
    logic signed [RATE_BITS-1:0]     angular_rate;
  } ddo_out_t;

  typedef struct packed {
    logic                    start;
    logic [HEADING_BITS-1:0] heading;
  } ddo_cordic_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [TRIG_BITS-1:0] sin_val;
    logic signed [TRIG_BITS-1:0] cos_val;
  } ddo_cordic_rsp_t;

  function automatic logic [30:0] atan_turn(input logic [ITER_BITS-1:0] idx);
    logic [30:0] v;
    case (idx)
      4'd0:    v = 31'd536870912;
      4'd1:    v = 31'd316933406;
      4'd2:    v = 31'd167458907;
      4'd3:    v = 31'd85004756;
      4'd4:    v = 31'd42667331;
      4'd5:    v = 31'd21354465;
      4'd6:    v = 31'd10679838;
      4'd7:    v = 31'd5340245;
      4'd8:    v = 31'd2670163;
      4'd9:    v = 31'd1335087;
      4'd10:   v = 31'd667544;
      4'd11:   v = 31'd333772;
      4'd12:   v = 31'd166886;
      4'd13:   v = 31'd83443;
      4'd14:   v = 31'd41722;
      4'd15:   v = 31'd20861;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ddo_mul.sv =====
module ddo_mul
  import ddo_pkg::*;
(
  input  logic                         clk,
  input  logic signed [MUL_A_BITS-1:0] op_a,
  input  logic signed [MUL_B_BITS-1:0] op_b,
  output logic signed [MUL_P_BITS-1:0] prod
);

  logic signed [MUL_P_BITS-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_BITS'(op_a) * MUL_P_BITS'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/ddo_cordic.sv =====
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  ddo_cordic_req_t req,
  output ddo_cordic_rsp_t rsp
);

  logic signed [CORDIC_BITS-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_BITS-1:0] x_nxt, y_nxt, z_nxt;
  logic [ITER_BITS-1:0]          iter_r;
  logic                          busy_r, done_r, flip_r;
  logic signed [CORDIC_BITS-1:0] xs, ys, at;
  logic [31:0]                   ang;
  logic                          flip;
  logic signed [CORDIC_BITS-1:0] neg_x, neg_y;

  assign ang  = {req.heading, {(32-HEADING_BITS){1'b0}}};
  assign flip = ang[31] ^ ang[30];

  assign xs = x_r >>> iter_r;
  assign ys = y_r >>> iter_r;
  assign at = CORDIC_BITS'(atan_turn(iter_r));

  always_comb begin
    if (!z_r[CORDIC_BITS-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_START;
      y_r    <= '0;
      z_r    <= CORDIC_BITS'(signed'({ang[31] ^ flip, ang[30:0]}));
      flip_r <= flip;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      iter_r <= '0;
    end else if (busy_r) begin
      iter_r <= iter_r + 1'b1;
      if (iter_r == ITER_BITS'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign neg_x = -x_r;
  assign neg_y = -y_r;

  assign rsp.done    = done_r;
  assign rsp.cos_val = flip_r ? neg_x[TRIG_BITS-1:0] : x_r[TRIG_BITS-1:0];
  assign rsp.sin_val = flip_r ? neg_y[TRIG_BITS-1:0] : y_r[TRIG_BITS-1:0];

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Differential-drive dead reckoning, one pose update per odometry request.
// The input channel (in_valid, in_stall, in_data) carries elapsed time and
// both wheel speeds; the output channel (out_valid, out_stall, out_data)
// returns the new pose, the mean wheel speed and the angular rate.
// An APB port at cfg_ sets the heading factor at byte address 0.
// Each request passes from acceptance to out_valid through the shift-and-add
// sine/cosine unit (16 rotations and its done flag), then through states in
// which one shared 34x32 multiplier forms the distances, the angular rate,
// the heading change and the projections in turn, and then the load of the
// output register. The next request is accepted only once the block is back
// in idle, after the last one has loaded the output register.
// in_stall is high while a request is in work. A finished result waits in
// the output register while out_stall is high; the block can take the next
// request meanwhile but holds its own result until the register frees.
// Reset clears the pose to zero, the heading to zero, the factor to 23179
// and drops out_valid.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ddo_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ddo_out_t                 out_data,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CORD = 4'd1;
  localparam logic [3:0] S_STEP = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_RATE = 4'd4;
  localparam logic [3:0] S_TH   = 4'd5;
  localparam logic [3:0] S_X    = 4'd6;
  localparam logic [3:0] S_Y    = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam int SAT_BITS = (POSITION_BITS > DELTA_BITS ? POSITION_BITS : DELTA_BITS) + 1;

  function automatic logic signed [POSITION_BITS-1:0] sat_add(
    input logic signed [POSITION_BITS-1:0] a,
    input logic signed [DELTA_BITS-1:0]    b
  );
    logic signed [SAT_BITS-1:0] s;
    logic signed [SAT_BITS-1:0] hi;
    logic signed [SAT_BITS-1:0] lo;
    logic signed [POSITION_BITS-1:0] r;
    s  = SAT_BITS'(a) + SAT_BITS'(b);
    hi = SAT_BITS'({1'b0, {(POSITION_BITS-1){1'b1}}});
    lo = -hi - SAT_BITS'(1);
    if (s > hi) begin
      r = {1'b0, {(POSITION_BITS-1){1'b1}}};
    end else if (s < lo) begin
      r = {1'b1, {(POSITION_BITS-1){1'b0}}};
    end else begin
      r = s[POSITION_BITS-1:0];
    end
    return r;
  endfunction

  logic [3:0]                      state_r, state_nxt;
  logic [FACTOR_BITS-1:0]          factor_r;
  logic [TIME_BITS-1:0]            dt_r;
  logic signed [SUM_BITS-1:0]      sum_r, diff_r;
  logic signed [STEP_BITS-1:0]     step_r, ddt_r;
  logic signed [RATE_BITS-1:0]     rate_r;
  logic [HEADING_BITS-1:0]         dth_r;
  logic signed [POSITION_BITS-1:0] pose_x_r, pose_y_r;
  logic [HEADING_BITS-1:0]         heading_r;
  logic                            out_valid_r;
  ddo_out_t                        out_data_r;

  logic                            in_accept, cfg_write;
  logic signed [MUL_A_BITS-1:0]    op_a;
  logic signed [MUL_B_BITS-1:0]    op_b;
  logic signed [MUL_P_BITS-1:0]    prod;
  logic signed [MUL_P_BITS-1:0]    prod_rnd_xy, prod_rnd_th, prod_rnd_rate;
  logic signed [DELTA_BITS-1:0]    delta;
  ddo_cordic_req_t                 cord_req;
  ddo_cordic_rsp_t                 cord_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_FACTOR);
  assign cfg_prdata = (cfg_paddr[2] == REG_FACTOR) ?
                      CFG_DATA_BITS'(factor_r) : '0;

  assign cord_req.start   = in_accept;
  assign cord_req.heading = heading_r;

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  always_comb begin
    case (state_r)
      S_STEP: begin
        op_a = MUL_A_BITS'(sum_r);
        op_b = MUL_B_BITS'({1'b0, dt_r});
      end
      S_DIFF: begin
        op_a = MUL_A_BITS'(diff_r);
        op_b = MUL_B_BITS'({1'b0, dt_r});
      end
      S_RATE: begin
        op_a = MUL_A_BITS'(diff_r);
        op_b = MUL_B_BITS'({1'b0, factor_r});
      end
      S_TH: begin
        op_a = MUL_A_BITS'(ddt_r);
        op_b = MUL_B_BITS'({1'b0, factor_r});
      end
      S_X: begin
        op_a = MUL_A_BITS'(step_r);
        op_b = cord_rsp.cos_val;
      end
      S_Y: begin
        op_a = MUL_A_BITS'(step_r);
        op_b = cord_rsp.sin_val;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ddo_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_rnd_xy   = prod + (MUL_P_BITS'(1) <<< (XY_SHIFT - 1));
  assign prod_rnd_th   = prod + (MUL_P_BITS'(1) <<< (TH_SHIFT - 1));
  assign prod_rnd_rate = prod + (MUL_P_BITS'(1) <<< (RATE_SHIFT - 1));
  assign delta         = prod_rnd_xy[MUL_P_BITS-1:XY_SHIFT];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_CORD;
      S_CORD: if (cord_rsp.done) state_nxt = S_STEP;
      S_STEP: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_RATE;
      S_RATE: state_nxt = S_TH;
      S_TH:   state_nxt = S_X;
      S_X:    state_nxt = S_Y;
      S_Y:    state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      factor_r    <= FACTOR_RESET;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        factor_r <= cfg_pwdata[FACTOR_BITS-1:0];
      end
      if (state_r == S_Y) begin
        pose_x_r <= sat_add(pose_x_r, delta);
      end
      if (state_r == S_FIN) begin
        pose_y_r  <= sat_add(pose_y_r, delta);
        heading_r <= heading_r + dth_r;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      dt_r   <= in_data.elapsed_time;
      sum_r  <= SUM_BITS'(in_data.left_speed) + SUM_BITS'(in_data.right_speed);
      diff_r <= SUM_BITS'(in_data.right_speed) - SUM_BITS'(in_data.left_speed);
    end
    if (state_r == S_DIFF) begin
      step_r <= prod[STEP_BITS-1:0];
    end
    if (state_r == S_RATE) begin
      ddt_r <= prod[STEP_BITS-1:0];
    end
    if (state_r == S_TH) begin
      rate_r <= prod_rnd_rate[RATE_SHIFT +: RATE_BITS];
    end
    if (state_r == S_X) begin
      dth_r <= prod_rnd_th[TH_SHIFT +: HEADING_BITS];
    end
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_data_r.position_x      <= pose_x_r;
      out_data_r.position_y      <= pose_y_r;
      out_data_r.heading_angle   <= heading_r;
      out_data_r.linear_velocity <= sum_r[SUM_BITS-1:1];
      out_data_r.angular_rate    <= rate_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ddo_checker.sv =====
module ddo_checker
  import ddo_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input ddo_out_t                 out_data,
  input logic                     cfg_psel,
  input logic                     cfg_penable,
  input logic                     cfg_pwrite,
  input logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  input logic [CFG_DATA_BITS-1:0] cfg_prdata,
  input logic                     cfg_pready
);

  logic in_acc, cfg_wr_factor;

  assign in_acc        = in_valid && !in_stall;
  assign cfg_wr_factor = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                         (cfg_paddr[2] == REG_FACTOR);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall && !$rose(out_valid))
    else $error("block not busy after taking a request");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_factor ##1 (cfg_paddr[2] == REG_FACTOR) |->
      cfg_prdata == CFG_DATA_BITS'($past(cfg_pwdata[15:0])))
    else $error("factor register read back wrong");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

// ===== dv/tb_differential_drive_odometry.sv =====
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
  import ddo_pkg::*;

  localparam logic [CFG_ADDR_BITS-1:0] FACTOR_ADDR = CFG_ADDR_BITS'(4 * REG_FACTOR);
  localparam logic [CFG_ADDR_BITS-1:0] UNUSED_ADDR = CFG_ADDR_BITS'(4 * (REG_FACTOR + 1));
  localparam int PHASES = 5;
  localparam int PHASE_REQUESTS = 105;
  localparam int SETTLE_CYCLES = 30;
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  class pose_scoreboard;
    longint est_x;
    longint est_y;
    logic [HEADING_BITS-1:0] est_heading;
    logic [FACTOR_BITS-1:0] factor;
    ddo_out_t expected_poses[$];
    int errors;
    int checked;

    function new();
      est_x = 0;
      est_y = 0;
      est_heading = '0;
      factor = FACTOR_RESET;
      errors = 0;
      checked = 0;
    endfunction

    task report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // The heading is folded into the front half-turn, then rotated by
    // shift-and-add steps; a folded heading negates both results.
    function void heading_trig(input logic [HEADING_BITS-1:0] hd,
                               output longint sin_v, output longint cos_v);
      logic [31:0] ang;
      logic [31:0] shifted;
      bit flip;
      longint x, y, z, xs, ys;
      ang = 32'(hd) << (32 - HEADING_BITS);
      shifted = ang + 32'h4000_0000;
      flip = shifted >= 32'h8000_0000;
      if (flip) begin
        ang = ang - 32'h8000_0000;
      end
      z = $signed(ang);
      x = CORDIC_START;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end
      end
      cos_v = flip ? -x : x;
      sin_v = flip ? -y : y;
    endfunction

    function longint clamp_position(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (POSITION_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_tick(input ddo_in_t t);
      longint dt, vl, vr, f, travel, spread, s, c, dx, dy, turn, rate;
      ddo_out_t want;
      dt = longint'(t.elapsed_time);
      vl = longint'(t.left_speed);
      vr = longint'(t.right_speed);
      f = longint'(factor);
      travel = dt * (vl + vr);
      spread = dt * (vr - vl);
      heading_trig(est_heading, s, c);
      dx = (travel * c + (longint'(1) <<< 42)) >>> XY_SHIFT;
      dy = (travel * s + (longint'(1) <<< 42)) >>> XY_SHIFT;
      turn = (spread * f + (longint'(1) <<< 27)) >>> TH_SHIFT;
      est_x = clamp_position(est_x + dx);
      est_y = clamp_position(est_y + dy);
      est_heading = est_heading + turn[HEADING_BITS-1:0];
      rate = ((vr - vl) * f + 2048) >>> RATE_SHIFT;
      want.position_x = est_x[POSITION_BITS-1:0];
      want.position_y = est_y[POSITION_BITS-1:0];
      want.heading_angle = est_heading;
      want.linear_velocity = SPEED_BITS'((vl + vr) >>> 1);
      want.angular_rate = rate[RATE_BITS-1:0];
      expected_poses.push_back(want);
    endfunction

    task compare_field(input string name, input longint got, input longint want,
                       input logic known);
      if (!known || got != want) begin
        report_error($sformatf("result %0d %s: got %0d, expected %0d",
                               checked, name, got, want));
      end
    endtask

    task check_pose(input ddo_out_t got);
      ddo_out_t want;
      if (expected_poses.size() == 0) begin
        report_error($sformatf("result with no request outstanding: %h", got));
      end else begin
        want = expected_poses.pop_front();
        compare_field("position_x", got.position_x, want.position_x,
                      !$isunknown(got.position_x));
        compare_field("position_y", got.position_y, want.position_y,
                      !$isunknown(got.position_y));
        compare_field("heading_angle", got.heading_angle, want.heading_angle,
                      !$isunknown(got.heading_angle));
        compare_field("linear_velocity", got.linear_velocity, want.linear_velocity,
                      !$isunknown(got.linear_velocity));
        compare_field("angular_rate", got.angular_rate, want.angular_rate,
                      !$isunknown(got.angular_rate));
        checked++;
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ddo_in_t in_data;
  logic out_valid;
  logic out_stall;
  ddo_out_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  pose_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_off_cycles;
  int settings;

  differential_drive_odometry dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off when one is asked for.
  initial begin : result_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pose(out_data);
    end
  end

  function automatic ddo_in_t make_tick(input int dt, input int vl, input int vr);
    ddo_in_t t;
    t.elapsed_time = 16'(dt);
    t.left_speed = 16'(vl);
    t.right_speed = 16'(vr);
    return t;
  endfunction

  function automatic int extreme_speed();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic ddo_in_t random_tick();
    int v;
    case ($urandom_range(9))
      0: return make_tick($urandom_range(1) ? 65535 : $urandom_range(2),
                          extreme_speed(), extreme_speed());
      1: return make_tick(0, $urandom, $urandom);
      2: begin
        v = $urandom;
        return make_tick($urandom, v, v);
      end
      3: begin
        v = $urandom_range(32767);
        return make_tick($urandom, -v, v);
      end
      4, 5: return make_tick($urandom_range(4000), $urandom_range(8192) - 4096,
                             $urandom_range(8192) - 4096);
      default: return make_tick($urandom, $urandom, $urandom);
    endcase
  endfunction

  task automatic send_tick(input ddo_in_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == FACTOR_ADDR) begin
      sb.factor = data[FACTOR_BITS-1:0];
      settings++;
    end
  endtask

  task automatic check_factor_reg();
    logic [CFG_DATA_BITS-1:0] data;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= FACTOR_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (data !== CFG_DATA_BITS'(sb.factor)) begin
      sb.report_error($sformatf("factor register read %h, expected %h", data, sb.factor));
    end
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    while (sb.expected_poses.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_poses.size() != 0) begin
      sb.report_error($sformatf("%0d results never arrived", sb.expected_poses.size()));
      sb.expected_poses.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int send_pcts [PHASES] = '{0, 81, 0, 33, 0};
    int stall_pcts [PHASES] = '{0, 0, 81, 33, 0};
    int factors [PHASES] = '{0, 1, 65535, 0, 23179};
    int f;

    sb = new();
    settings = 1;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_factor_reg();

    // Zero elapsed time still reports both velocities.
    send_tick(make_tick(0, 32767, -32768));
    send_tick(make_tick(0, -32768, 32767));
    send_tick(make_tick(0, 0, 0));
    send_tick(make_tick(65535, 32767, 32767));
    send_tick(make_tick(65535, -32768, -32768));
    send_tick(make_tick(65535, -1, -1));
    // Full-speed spins wrap the heading; each is followed by a step on it.
    for (int i = 0; i < 8; i++) begin
      send_tick(make_tick(65535 - 4099 * i, -32768, 32767));
      send_tick(make_tick(65535, 32767, 32767));
    end
    send_tick(make_tick(65535, 32767, -32768));
    end_burst();

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 2) begin
        cfg_write(UNUSED_ADDR, $urandom);
        check_factor_reg();
      end
      f = (ph == 3) ? $urandom_range(65535, 1) : factors[ph];
      cfg_write(FACTOR_ADDR, {16'($urandom), 16'(f)});
      check_factor_reg();
      send_idle_pct = send_pcts[ph];
      stall_pct = stall_pcts[ph];
      if (ph == 0) begin
        hold_off_cycles = 400;
      end
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        send_tick(random_tick());
      end
      end_burst();
    end

    stall_pct = 0;
    wait_idle();
    $display("Checked %0d odometry requests over %0d factor settings with idle gaps and",
             sb.checked, settings);
    $display("output back-pressure, including zero elapsed time and heading wrap.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== differential_drive_odometry.f =====
rtl/ddo_pkg.sv
rtl/ddo_mul.sv
rtl/ddo_cordic.sv
rtl/differential_drive_odometry.sv
rtl/ddo_checker.sv
dv/tb_differential_drive_odometry.sv
